// ===== hdl/u8uri_pkg.sv =====
// Shared types, constants and helper functions for the UTF-8 encoder with URI escaping.
package u8uri_pkg;

  localparam int CODE_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_URI_ESCAPE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY = 2'd2;

  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 16'd256;

  localparam logic [BYTE_W-1:0] PERCENT_CHAR = 8'h25;
  localparam logic [BYTE_W-1:0] TERMINATOR   = 8'h00;

  // One queued command: up to three UTF-8 bytes, each sent raw or as %hh.
  typedef struct packed {
    logic [2:0][BYTE_W-1:0] bytes;
    logic [1:0]             nbytes;
    logic                   esc;
    logic [COUNT_W-1:0]     char_count;
    logic                   stopped;
  } cmd_t;

  function automatic logic uri_safe(input logic [BYTE_W-1:0] c);
    logic safe;
    safe = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
           (c == 8'h2E) || (c == 8'h2F) || (c == 8'h3A) ||
           (c == 8'h26) || (c == 8'h5F) || (c == 8'h3F);
    return safe;
  endfunction

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h57 + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage

// ===== hdl/u8uri_front.sv =====
// Front end: configuration registers, string state, room checks and command generation.
module u8uri_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [u8uri_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [u8uri_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [u8uri_pkg::CODE_W-1:0]     in_code_unit,
  output logic                             cmd_push,
  output u8uri_pkg::cmd_t                  cmd_data,
  input  logic                             q_full
);
  import u8uri_pkg::*;

  logic               wide_mode_r, wide_mode_nxt;
  logic               uri_escape_r, uri_escape_nxt;
  logic [COUNT_W-1:0] capacity_r, capacity_nxt;
  logic [COUNT_W-1:0] bytes_r, bytes_nxt;
  logic [COUNT_W-1:0] chars_r, chars_nxt;
  logic               stopped_r, stopped_nxt;

  logic [CODE_W-1:0]  w;
  logic               accept;
  logic               is_term;
  logic               cls1;
  logic               cls2;
  logic [1:0]         nb;
  logic [3:0]         nb3;
  logic               esc_item;
  logic               fit_plain;
  logic               fit_esc;
  logic [3:0]         nout;
  logic [COUNT_W:0]   need_plain;
  logic [COUNT_W:0]   need_esc;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;

  always_comb begin
    w = wide_mode_r ? in_code_unit : {8'd0, in_code_unit[7:0]};
    is_term = (w == '0);
    cls1 = (w < 16'h0080);
    cls2 = (w < 16'h0800);
    nb = cls1 ? 2'd1 : (cls2 ? 2'd2 : 2'd3);
    nb3 = {1'b0, nb, 1'b0} + {2'd0, nb};
    esc_item = uri_escape_r && (!cls1 || !uri_safe(w[7:0]));
    // j < (capacity - 1) - k is the same as j + k + 1 < capacity, with no sign.
    need_plain = {1'b0, bytes_r} + {15'd0, nb};
    need_esc   = {1'b0, bytes_r} + {13'd0, nb3} + 17'd1;
    fit_plain = need_plain < {1'b0, capacity_r};
    fit_esc   = need_esc < {1'b0, capacity_r};
    nout = esc_item ? nb3 : {2'd0, nb};
  end

  always_comb begin
    bytes_nxt   = bytes_r;
    chars_nxt   = chars_r;
    stopped_nxt = stopped_r;
    cmd_push    = 1'b0;
    cmd_data.bytes      = '0;
    cmd_data.nbytes     = nb;
    cmd_data.esc        = esc_item;
    cmd_data.char_count = chars_r + 16'd1;
    cmd_data.stopped    = 1'b0;
    if (cls1) begin
      cmd_data.bytes[0] = w[7:0];
    end else if (cls2) begin
      cmd_data.bytes[0] = {3'b110, w[10:6]};
      cmd_data.bytes[1] = {2'b10, w[5:0]};
    end else begin
      cmd_data.bytes[0] = {4'b1110, w[15:12]};
      cmd_data.bytes[1] = {2'b10, w[11:6]};
      cmd_data.bytes[2] = {2'b10, w[5:0]};
    end
    if (accept) begin
      if (is_term) begin
        cmd_push            = 1'b1;
        cmd_data.bytes      = '0;
        cmd_data.bytes[0]   = TERMINATOR;
        cmd_data.nbytes     = 2'd1;
        cmd_data.esc        = 1'b0;
        cmd_data.char_count = chars_r;
        cmd_data.stopped    = stopped_r;
        bytes_nxt   = '0;
        chars_nxt   = '0;
        stopped_nxt = 1'b0;
      end else if (!stopped_r) begin
        if (!fit_plain) begin
          stopped_nxt = 1'b1;
        end else if (!esc_item || fit_esc) begin
          // An escaped character without room is silently dropped.
          cmd_push  = 1'b1;
          bytes_nxt = bytes_r + {12'd0, nout};
          chars_nxt = chars_r + 16'd1;
        end
      end
    end
  end

  always_comb begin
    wide_mode_nxt  = wide_mode_r;
    uri_escape_nxt = uri_escape_r;
    capacity_nxt   = capacity_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_WIDE_MODE:    wide_mode_nxt  = cfg_data[0];
        REG_URI_ESCAPE:   uri_escape_nxt = cfg_data[0];
        REG_OUT_CAPACITY: capacity_nxt   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_mode_r  <= 1'b0;
      uri_escape_r <= 1'b0;
      capacity_r   <= CAPACITY_RESET;
      bytes_r      <= '0;
      chars_r      <= '0;
      stopped_r    <= 1'b0;
    end else begin
      wide_mode_r  <= wide_mode_nxt;
      uri_escape_r <= uri_escape_nxt;
      capacity_r   <= capacity_nxt;
      bytes_r      <= bytes_nxt;
      chars_r      <= chars_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

endmodule

// ===== hdl/u8uri_queue.sv =====
// Short command queue between the front end and the byte emitter.
module u8uri_queue #(
  parameter int DEPTH = u8uri_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u8uri_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output u8uri_pkg::cmd_t head,
  output logic            empty
);
  import u8uri_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign head    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/u8uri_back.sv =====
// Back end: expands queued commands into output register bytes, one per cycle unless stalled.
module u8uri_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  u8uri_pkg::cmd_t                     head,
  input  logic                                q_empty,
  output logic                                q_pop,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [u8uri_pkg::BYTE_W-1:0]        out_byte,
  output logic                                out_last_byte,
  output logic [u8uri_pkg::COUNT_W-1:0]       out_char_count,
  output logic                                out_stopped_flag
);
  import u8uri_pkg::*;

  logic               valid_r, valid_nxt;
  logic [1:0]         unit_r, unit_nxt;
  logic [1:0]         sub_r, sub_nxt;
  logic [BYTE_W-1:0]  byte_r;
  logic               last_r;
  logic [COUNT_W-1:0] count_r;
  logic               stopped_r;

  logic               advance;
  logic [BYTE_W-1:0]  raw;
  logic [BYTE_W-1:0]  cur_byte;
  logic               cur_last;

  // A byte is produced when a command waits and the output register is free or being drained.
  assign advance = !q_empty && (!valid_r || out_pop);

  always_comb begin
    raw = head.bytes[unit_r];
    cur_byte = raw;
    if (head.esc) begin
      case (sub_r)
        2'd0:    cur_byte = PERCENT_CHAR;
        2'd1:    cur_byte = hex_digit(raw[7:4]);
        default: cur_byte = hex_digit(raw[3:0]);
      endcase
    end
    cur_last = (unit_r == head.nbytes - 2'd1) && (!head.esc || sub_r == 2'd2);
  end

  always_comb begin
    unit_nxt  = unit_r;
    sub_nxt   = sub_r;
    q_pop     = 1'b0;
    valid_nxt = valid_r;
    if (out_pop && valid_r) begin
      valid_nxt = 1'b0;
    end
    if (advance) begin
      valid_nxt = 1'b1;
      if (cur_last) begin
        q_pop    = 1'b1;
        unit_nxt = 2'd0;
        sub_nxt  = 2'd0;
      end else if (head.esc && sub_r != 2'd2) begin
        sub_nxt = sub_r + 2'd1;
      end else begin
        sub_nxt  = 2'd0;
        unit_nxt = unit_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r    <= cur_byte;
      last_r    <= cur_last;
      count_r   <= head.char_count;
      stopped_r <= head.stopped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      unit_r  <= 2'd0;
      sub_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      unit_r  <= unit_nxt;
      sub_r   <= sub_nxt;
    end
  end

  assign out_empty        = !valid_r;
  assign out_byte         = byte_r;
  assign out_last_byte    = last_r;
  assign out_char_count   = count_r;
  assign out_stopped_flag = stopped_r;

endmodule

// ===== hdl/utf8_encoder_uri_escape.sv =====
// Top level of the UTF-8 encoder with optional percent escaping.
// Each accepted code unit is encoded to one to three UTF-8 bytes, or three to nine bytes when
// percent escaping applies, and code 0 produces a single terminator byte carrying the final
// character count. The output side delivers one byte per clock while out_pop keeps up, and the
// byte emitter is what sets this rate. The front end takes one request per clock as long as the
// command queue (QUEUE_DEPTH entries) has room, so bursts of input are absorbed while earlier
// bytes drain. Characters that emit nothing (after a stop, or dropped for lack of room) take no
// queue entry and no back-end time. Configuration writes are always accepted, as cfg_ready is
// tied high, and take effect from the next request on.
module utf8_encoder_uri_escape #(
  parameter int QUEUE_DEPTH = u8uri_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [u8uri_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [u8uri_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [u8uri_pkg::CODE_W-1:0]     in_code_unit,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [u8uri_pkg::BYTE_W-1:0]     out_byte,
  output logic                             out_last_byte,
  output logic [u8uri_pkg::COUNT_W-1:0]    out_char_count,
  output logic                             out_stopped_flag
);
  import u8uri_pkg::*;

  logic cmd_push;
  cmd_t cmd_data;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_head;

  u8uri_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_code_unit (in_code_unit),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_data),
    .q_full       (q_full)
  );

  u8uri_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  u8uri_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_last_byte    (out_last_byte),
    .out_char_count   (out_char_count),
    .out_stopped_flag (out_stopped_flag)
  );

endmodule

// ===== verif/utf8_encoder_uri_escape_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the UTF-8 encoder with optional URI percent escaping.
module utf8_encoder_uri_escape_test;
  import u8uri_pkg::*;

  localparam int SETTLE_CYCLES = 4 * QUEUE_DEPTH_DEF + 4;
  localparam int LONG_STALL    = 80;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 11;

  typedef struct {
    logic [BYTE_W-1:0]  value;
    logic               last;
    logic [COUNT_W-1:0] count;
    logic               stopped;
  } utf8_byte_t;

  // Tracks the encoder's string state and the bytes it still owes us.
  class uri_encoding_predictor;
    bit                 wide_mode;
    bit                 uri_escape;
    logic [COUNT_W-1:0] capacity;
    logic [COUNT_W-1:0] bytes_written;
    logic [COUNT_W-1:0] chars_converted;
    bit                 output_stopped;
    logic [BYTE_W-1:0]  staged[$];
    utf8_byte_t         awaited[$];
    int                 mismatches;
    int                 bytes_checked;
    int                 strings_ended;
    int                 strings_stopped;
    int                 chars_dropped;

    function new();
      wide_mode       = 1'b0;
      uri_escape      = 1'b0;
      capacity        = CAPACITY_RESET;
      bytes_written   = '0;
      chars_converted = '0;
      output_stopped  = 1'b0;
      mismatches      = 0;
      bytes_checked   = 0;
      strings_ended   = 0;
      strings_stopped = 0;
      chars_dropped   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WIDE_MODE:    wide_mode = data[0];
        REG_URI_ESCAPE:   uri_escape = data[0];
        REG_OUT_CAPACITY: capacity = data;
        default: ;
      endcase
    endfunction

    function bit is_uri_safe(logic [CODE_W-1:0] c);
      return c inside {[16'h30:16'h39], [16'h41:16'h5A], [16'h61:16'h7A],
                       16'h2E, 16'h2F, 16'h3A, 16'h26, 16'h5F, 16'h3F};
    endfunction

    function logic [BYTE_W-1:0] nibble_char(logic [3:0] nib);
      return (nib < 4'd10) ? 8'h30 + nib : 8'h61 + nib - 8'd10;
    endfunction

    function void stage(logic [BYTE_W-1:0] b, bit escaped);
      if (escaped) begin
        staged.push_back(PERCENT_CHAR);
        staged.push_back(nibble_char(b[7:4]));
        staged.push_back(nibble_char(b[3:0]));
      end else begin
        staged.push_back(b);
      end
    endfunction

    function void encode_code_unit(logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] w;
      int lim;
      int j;
      w = wide_mode ? code : {8'h00, code[7:0]};
      // One byte of the buffer is always held back for the terminator.
      lim = int'(capacity) - 1;
      j = int'(bytes_written);
      staged.delete();
      if (w == '0) begin
        awaited.push_back('{TERMINATOR, 1'b1, chars_converted, output_stopped});
        strings_ended++;
        if (output_stopped) strings_stopped++;
        bytes_written   = '0;
        chars_converted = '0;
        output_stopped  = 1'b0;
        return;
      end
      if (output_stopped) return;
      if (w < 16'h80) begin
        if (j >= lim) begin
          output_stopped = 1'b1;
        end else if (!uri_escape || is_uri_safe(w)) begin
          stage(w[7:0], 1'b0);
        end else if (j < lim - 3) begin
          stage(w[7:0], 1'b1);
        end else begin
          chars_dropped++;
        end
      end else if (w < 16'h800) begin
        if (j >= lim - 1) begin
          output_stopped = 1'b1;
        end else if (!uri_escape || j < lim - 6) begin
          stage({3'b110, w[10:6]}, uri_escape);
          stage({2'b10, w[5:0]}, uri_escape);
        end else begin
          chars_dropped++;
        end
      end else begin
        if (j >= lim - 2) begin
          output_stopped = 1'b1;
        end else if (!uri_escape || j < lim - 9) begin
          stage({4'b1110, w[15:12]}, uri_escape);
          stage({2'b10, w[11:6]}, uri_escape);
          stage({2'b10, w[5:0]}, uri_escape);
        end else begin
          chars_dropped++;
        end
      end
      if (staged.size() > 0) begin
        bytes_written   = bytes_written + COUNT_W'(staged.size());
        chars_converted = chars_converted + COUNT_W'(1);
        foreach (staged[k]) begin
          awaited.push_back('{staged[k], k == staged.size() - 1, chars_converted,
                              output_stopped});
        end
      end
    endfunction

    function void match_byte(logic [BYTE_W-1:0] value, logic last,
                             logic [COUNT_W-1:0] count, logic stopped);
      utf8_byte_t want;
      bytes_checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: expected no byte, got byte %02h last %0b count %0d stopped %0b",
                 $time, value, last, count, stopped);
        return;
      end
      want = awaited.pop_front();
      if (want.value !== value || want.last !== last || want.count !== count ||
          want.stopped !== stopped) begin
        mismatches++;
        $display("%0t: expected byte %02h last %0b count %0d stopped %0b", $time,
                 want.value, want.last, want.count, want.stopped);
        $display("%0t:      got byte %02h last %0b count %0d stopped %0b", $time,
                 value, last, count, stopped);
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_push;
  logic                  in_full;
  logic [CODE_W-1:0]     in_code_unit;
  logic                  out_empty;
  logic                  out_pop;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_last_byte;
  logic [COUNT_W-1:0]    out_char_count;
  logic                  out_stopped_flag;

  uri_encoding_predictor enc = new();
  int tx_idle_pct;
  int rx_idle_pct;
  int items_sent;
  bit stall_request;

  utf8_encoder_uri_escape uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_code_unit     (in_code_unit),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_last_byte    (out_last_byte),
    .out_char_count   (out_char_count),
    .out_stopped_flag (out_stopped_flag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: checks every popped byte and decides pop at each falling edge.
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        enc.match_byte(out_byte, out_last_byte, out_char_count, out_stopped_flag);
      end
      @(negedge clk);
      if (stall_request) begin
        hold_left = LONG_STALL;
        stall_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with in_push still high.
  task automatic send_code(input logic [CODE_W-1:0] code);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push      <= 1'b1;
    in_code_unit <= code;
    do @(posedge clk); while (in_full);
    enc.encode_code_unit(code);
    items_sent++;
    @(negedge clk);
  endtask

  // Holds off new requests until every expected byte is out and the queue has settled.
  task automatic wait_idle();
    in_push <= 1'b0;
    while (enc.outstanding() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    enc.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_config(input bit wide, input bit escape, input logic [COUNT_W-1:0] cap);
    wait_idle();
    write_reg(REG_WIDE_MODE, {15'd0, wide});
    write_reg(REG_URI_ESCAPE, {15'd0, escape});
    write_reg(REG_OUT_CAPACITY, cap);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CODE_W-1:0] pick_code(input bit wide);
    logic [CODE_W-1:0] c;
    case ($urandom_range(9))
      0, 1, 2: c = CODE_W'($urandom_range(16'h21, 16'h7E));
      3:       c = CODE_W'($urandom_range(16'h01, 16'h7F));
      4, 5:    c = CODE_W'($urandom_range(16'h80, 16'h7FF));
      6, 7:    c = CODE_W'($urandom_range(16'h800, 16'hFFFF));
      8: begin
        case ($urandom_range(5))
          0:       c = 16'h0001;
          1:       c = 16'h007F;
          2:       c = 16'h0080;
          3:       c = 16'h07FF;
          4:       c = 16'h0800;
          default: c = 16'hFFFF;
        endcase
      end
      default: c = CODE_W'($urandom);
    endcase
    // In byte mode the upper half is don't-care, so fill it with noise.
    if (!wide) c[15:8] = 8'($urandom);
    return c;
  endfunction

  // Mostly well-formed strings; now and then the terminator is left off.
  task automatic send_string(input bit wide, input int max_len);
    int len;
    len = $urandom_range(0, max_len);
    repeat (len) send_code(pick_code(wide));
    if ($urandom_range(7) != 0) begin
      send_code(wide ? 16'h0000 : {8'($urandom), 8'h00});
    end
  endtask

  initial begin : stimulus
    logic [COUNT_W-1:0] cap;
    int phase_end;
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_push       = 1'b0;
    in_code_unit  = '0;
    items_sent    = 0;
    stall_request = 1'b0;
    tx_idle_pct   = 29;
    rx_idle_pct   = 75;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: byte mode, no escaping, capacity 256.
    send_code(16'h0041);
    send_code(16'h007F);
    send_code(16'h0080);
    send_code(16'h00FF);
    send_code(16'h1234);
    // Only the low byte counts, so this one ends the string.
    send_code(16'hAB00);

    set_config(1'b1, 1'b1, 16'd256);
    send_code(16'h0061);
    send_code(16'h0020);
    send_code(16'h0026);
    send_code(16'h00FF);
    send_code(16'h07FF);
    send_code(16'h0800);
    send_code(16'hFFFF);
    send_code(16'h0000);

    // Eight bytes of room: an escape that no longer fits is dropped, then a plain
    // character that no longer fits stops output until the terminator.
    set_config(1'b1, 1'b1, 16'd8);
    send_code(16'h0041);
    send_code(16'h0020);
    send_code(16'h0020);
    send_code(16'h0042);
    send_code(16'h0100);
    send_code(16'h0043);
    send_code(16'h0044);
    send_code(16'h0045);
    send_code(16'h0046);
    send_code(16'h0000);

    // A capacity of one leaves room for the terminator alone.
    set_config(1'b0, 1'b0, 16'd1);
    send_code(16'h0078);
    send_code(16'h0000);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 4) begin
        tx_idle_pct = 29;
        rx_idle_pct = 75;
      end else if (phase < 8) begin
        tx_idle_pct = 75;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (phase)
        1:       cap = 16'd1;
        2, 7:    cap = 16'hFFFF;
        4, 10:   cap = COUNT_W'($urandom_range(2, 12));
        default: cap = COUNT_W'($urandom_range(13, 64));
      endcase
      set_config(phase[0], phase[1], cap);
      // Stop popping for a long while so the queue fills and pushes back.
      if (phase == 9) stall_request = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_string(phase[0], (cap < 16) ? 4 : 10);
    end

    wait_idle();
    $display("Covered %0d code units in byte and wide mode, with and without escaping,",
             items_sent);
    $display("%0d bytes checked, %0d strings ended (%0d stopped), %0d characters dropped.",
             enc.bytes_checked, enc.strings_ended, enc.strings_stopped, enc.chars_dropped);
    if (enc.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/u8uri_pkg.sv
hdl/u8uri_front.sv
hdl/u8uri_queue.sv
hdl/u8uri_back.sv
hdl/utf8_encoder_uri_escape.sv
verif/utf8_encoder_uri_escape_test.sv
